// ===== src/rsb_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsb_pkg
// Shared constants and types for the rank sort block and its insertion cells.
// ----------------------------------------------------------------------------
package rsb_pkg;

  localparam int unsigned RSB_DATA_W    = 32;
  localparam int unsigned RSB_MAX_ELEMS = 64;

  // Contents of one cell of the sorting chain
  typedef struct packed {
    logic                  valid;
    logic [RSB_DATA_W-1:0] value;
  } rsb_cell_t;

  // Chain-wide control broadcast to every cell
  typedef struct packed {
    logic ins;  // insert the broadcast value
    logic pop;  // shift the chain one place toward cell 0
  } rsb_ctrl_t;

  typedef enum logic {
    RSB_LOAD,
    RSB_DRAIN
  } rsb_state_e;

endpackage : rsb_pkg
`default_nettype wire

// ===== src/rsb_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rsb_cell
// One insertion cell: holds one value, compares it with the broadcast value
// and either keeps it, takes its left neighbor's, takes the new value, or
// takes its right neighbor's when the chain drains.
// ----------------------------------------------------------------------------
module rsb_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  rsb_pkg::rsb_ctrl_t ctrl_i,
  input  logic [rsb_pkg::RSB_DATA_W-1:0] x_i,
  input  rsb_pkg::rsb_cell_t left_i,
  input  logic              left_gt_i,
  input  rsb_pkg::rsb_cell_t right_i,
  output logic              gt_o,
  output rsb_pkg::rsb_cell_t cell_o
);
  import rsb_pkg::*;

  logic                  valid_q;
  logic [RSB_DATA_W-1:0] value_q;
  rsb_cell_t             cell_d, cell_q;

  assign cell_q = '{valid: valid_q, value: value_q};

  always_comb begin
    // An empty cell counts as greater, so the new value lands in the first gap
    gt_o   = !cell_q.valid || ($signed(cell_q.value) > $signed(x_i));
    cell_d = cell_q;
    if (ctrl_i.pop) begin
      cell_d = right_i;
    end else if (ctrl_i.ins && gt_o) begin
      if (left_gt_i) begin
        cell_d = left_i;
      end else begin
        cell_d.valid = 1'b1;
        cell_d.value = x_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= cell_d.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= cell_d.value;
  end

  assign cell_o = cell_q;

endmodule : rsb_cell
`default_nettype wire

// ===== src/rank_sort_block.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rank_sort_block
// Stable sort of one block of signed 32-bit values in a chain of insertion
// cells.
// ----------------------------------------------------------------------------
// Values stream in one item per cycle while the chain loads; each one is
// inserted into a chain of MAX_ELEMS cells that always holds the block in
// ascending order, equal values kept in arrival order. The item marked tlast
// closes the block: the chain then shifts toward cell 0 and emits one sorted
// item per cycle while the output is not stalled. The closing item moves the
// state to drain, and each result is registered in the output stage. The
// input is not ready while the chain drains.
// Values beyond MAX_ELEMS are dropped and every result of that block carries
// tuser = 1 (overflow). The last result of a block carries tlast.
// ----------------------------------------------------------------------------
module rank_sort_block #(
  parameter int unsigned MAX_ELEMS = rsb_pkg::RSB_MAX_ELEMS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [rsb_pkg::RSB_DATA_W-1:0] s_axis_tdata_i,   // [31:0] value
  input  logic                           s_axis_tlast_i,   // last
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [rsb_pkg::RSB_DATA_W-1:0] m_axis_tdata_o,   // [31:0] sorted_value
  output logic                           m_axis_tlast_o,   // end_of_run
  output logic                           m_axis_tuser_o    // [0] overflow
);
  import rsb_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_ELEMS + 1);
  localparam logic [CntW-1:0] Full = CntW'(MAX_ELEMS);

  rsb_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic drop_q, drop_d;
  logic run_ovf_q, run_ovf_d;

  logic m_valid_q;
  logic [RSB_DATA_W-1:0] m_data_q;
  logic m_last_q, m_user_q;

  rsb_ctrl_t ctrl;
  logic accept, pop, last_pop;
  rsb_cell_t cells [MAX_ELEMS];
  logic gt [MAX_ELEMS];
  logic [MAX_ELEMS-1:0] valid_vec;

  assign s_axis_tready_o = (state_q == RSB_LOAD);
  assign accept = s_axis_tvalid_i && s_axis_tready_o;
  assign pop = (state_q == RSB_DRAIN) && cells[0].valid && (!m_valid_q || m_axis_tready_i);
  // Cell 1 empty: the value leaving cell 0 is the last of the block
  assign last_pop = !valid_vec[1];

  always_comb begin
    ctrl.ins = accept && (cnt_q != Full);
    ctrl.pop = pop;
  end

  // Chain of insertion cells, cell 0 holds the smallest value
  for (genvar i = 0; i < MAX_ELEMS; i++) begin : g_cell
    rsb_cell_t left, right;
    logic left_gt;
    if (i == 0) begin : g_head
      assign left    = '{valid: 1'b1, value: s_axis_tdata_i};
      assign left_gt = 1'b1;
    end else begin : g_body
      assign left    = cells[i-1];
      assign left_gt = gt[i-1];
    end
    if (i == MAX_ELEMS - 1) begin : g_tail
      assign right = '0;
    end else begin : g_inner
      assign right = cells[i+1];
    end

    rsb_cell u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .ctrl_i    (ctrl),
      .x_i       (s_axis_tdata_i),
      .left_i    (left),
      .left_gt_i (left_gt),
      .right_i   (right),
      .gt_o      (gt[i]),
      .cell_o    (cells[i])
    );
    assign valid_vec[i] = cells[i].valid;
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    drop_d    = drop_q;
    run_ovf_d = run_ovf_q;
    unique case (state_q)
      RSB_LOAD: begin
        if (accept) begin
          if (cnt_q != Full) begin
            cnt_d = cnt_q + 1'b1;
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast_i) begin
            // Close the block: latch its overflow and start over for the next
            run_ovf_d = drop_q || (cnt_q == Full);
            cnt_d     = '0;
            drop_d    = 1'b0;
            state_d   = RSB_DRAIN;
          end
        end
      end
      RSB_DRAIN: begin
        if (pop && last_pop) begin
          state_d = RSB_LOAD;
        end
      end
      default: state_d = RSB_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= RSB_LOAD;
      cnt_q     <= '0;
      drop_q    <= 1'b0;
      run_ovf_q <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      drop_q    <= drop_d;
      run_ovf_q <= run_ovf_d;
      if (pop) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      m_data_q <= cells[0].value;
      m_last_q <= last_pop;
      m_user_q <= run_ovf_q;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tuser_o  = m_user_q;

`ifndef SYNTHESIS
  // Occupied cells always form an unbroken run starting at cell 0
  a_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((valid_vec >> 1) & ~valid_vec) == '0)
    else $error("rank_sort_block: gap in cell chain");

  // While loading, the fill count matches the occupied cells
  a_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == RSB_LOAD) |-> ($countones(valid_vec) == int'(cnt_q)))
    else $error("rank_sort_block: fill count out of step with chain");

  // Draining never runs on an empty chain
  a_drain_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == RSB_DRAIN) |-> cells[0].valid)
    else $error("rank_sort_block: drain with empty chain");

  // Fill count stays within capacity
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= Full)
    else $error("rank_sort_block: fill count beyond capacity");
`endif

endmodule : rank_sort_block
`default_nettype wire

// ===== bench/rank_sort_block_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_sort_block_tb
// Self-checking bench for the stable rank sort of signed 32-bit blocks.
// ----------------------------------------------------------------------------
// Streams blocks of values into the sorter and predicts every sorted item
// with an independent rank count over the values held so far. The opening
// section walks a table of hand-picked blocks. The random section follows
// with blocks of mixed sizes and value mixes. These include one block that
// exactly fills the store and one that overruns it with the closing item
// dropped. The sender idles in bursts and the receiver stalls in changing
// modes. Every output item is compared field by field with the oldest
// prediction.
// ----------------------------------------------------------------------------
module rank_sort_block_tb;
  import rsb_pkg::*;

  localparam int CAP = RSB_MAX_ELEMS;

  typedef struct packed {
    logic [RSB_DATA_W-1:0] value;
    logic                  last;
    logic                  ovf;
  } sorted_item_t;

  // Directed block row; want is used only on single-value blocks
  typedef struct packed {
    logic [RSB_DATA_W-1:0] value;
    logic                  last;
    logic                  typed;
    logic [RSB_DATA_W-1:0] want;
  } dir_row_t;

  localparam int DIR_ROWS = 23;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic [RSB_DATA_W-1:0] s_data = '0;
  logic                  s_last = 1'b0;
  logic                  m_ready = 1'b0;
  logic                  s_axis_tready_o;
  logic                  m_axis_tvalid_o;
  logic [RSB_DATA_W-1:0] m_axis_tdata_o;
  logic                  m_axis_tlast_o;
  logic                  m_axis_tuser_o;

  // Predictor state
  logic signed [RSB_DATA_W-1:0] held_vals [CAP];
  int unsigned                  held_cnt = 0;
  bit                           held_drop = 1'b0;
  sorted_item_t                 sorted_run [$];
  sorted_item_t                 sorted_due [$];
  sorted_item_t                 want_item;

  int mismatches = 0;
  int items_sent = 0;
  int results_seen = 0;
  int blocks_closed = 0;
  int overflow_blocks = 0;
  int burst_left = 0;
  int stall_cycle = 0;
  int stall_mode = 0;

  dir_row_t dir_rows [DIR_ROWS] = '{
    // single-value blocks: extremes, zero and minus one
    '{32'h7FFF_FFFF, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000},
    '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF},
    // mixed block with duplicates and both extremes
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0005, 1'b0, 1'b0, 32'h0},
    '{32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'hFFFF_FFFD, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0000, 1'b1, 1'b0, 32'h0},
    // already ascending
    '{32'h0000_0001, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0004, 1'b1, 1'b0, 32'h0},
    // descending
    '{32'h0000_0003, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0002, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0},
    // all equal
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0007, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0007, 1'b1, 1'b0, 32'h0},
    // signed order: -1 sorts below 1
    '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{32'h0000_0001, 1'b1, 1'b0, 32'h0}
  };

  rank_sort_block uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_valid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_data),
    .s_axis_tlast_i  (s_last),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_ready),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Store one value; on a closing item rank every held value and emit the run
  function automatic void absorb_value(logic [RSB_DATA_W-1:0] v, bit l);
    logic [RSB_DATA_W-1:0] order [CAP];
    int unsigned           rank;
    int unsigned           n;
    if (held_cnt < CAP) begin
      held_vals[held_cnt] = v;
      held_cnt++;
    end else begin
      held_drop = 1'b1;
    end
    sorted_run.delete();
    if (!l) return;
    n = held_cnt;
    for (int unsigned i = 0; i < n; i++) begin
      rank = 0;
      for (int unsigned j = 0; j < n; j++) begin
        if (held_vals[j] < held_vals[i] || (held_vals[j] == held_vals[i] && j < i)) rank++;
      end
      order[rank] = held_vals[i];
    end
    for (int unsigned k = 0; k < n; k++) begin
      sorted_run.push_back('{order[k], (k + 1 == n), held_drop});
    end
    blocks_closed++;
    if (held_drop) overflow_blocks++;
    held_cnt = 0;
    held_drop = 1'b0;
  endfunction

  function automatic logic [RSB_DATA_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      5, 6:    return RSB_DATA_W'($signed($urandom_range(0, 8)) - 4);
      7:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      8:       return 32'h8000_0000 + $urandom_range(0, 3);
      9:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      default: return $urandom;
    endcase
  endfunction

  // Offer one item, hold it until accepted, then record what it should produce
  task automatic push_item(input logic [RSB_DATA_W-1:0] v, input bit l, input bit typed,
                           input logic [RSB_DATA_W-1:0] tv);
    int gap;
    if (burst_left == 0) begin
      s_valid <= 1'b0;
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 16);
    end
    s_valid <= 1'b1;
    s_data  <= v;
    s_last  <= l;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
    absorb_value(v, l);
    if (typed) begin
      sorted_due.push_back('{tv, 1'b1, 1'b0});
    end else begin
      foreach (sorted_run[k]) sorted_due.push_back(sorted_run[k]);
    end
  endtask

  // Hold off the sender until every predicted item has come out
  task automatic hold_until_drained();
    s_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (sorted_due.size() != 0);
  endtask

  // Receiver stall pattern: periodically switch to a randomly chosen mode
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 48 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0:       m_ready <= 1'b1;
      1:       m_ready <= ($urandom_range(0, 3) != 0);
      2:       m_ready <= ($urandom_range(0, 3) == 0);
      default: m_ready <= (stall_cycle % 5 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_ready) begin
      if (sorted_due.size() == 0) begin
        $display("%0t: unexpected item, expected none, got value %h last %b overflow %b",
                 $time, m_axis_tdata_o, m_axis_tlast_o, m_axis_tuser_o);
        mismatches++;
      end else begin
        want_item = sorted_due.pop_front();
        results_seen++;
        if (m_axis_tdata_o !== want_item.value) begin
          $display("%0t: sorted value mismatch, expected %h, got %h",
                   $time, want_item.value, m_axis_tdata_o);
          mismatches++;
        end
        if (m_axis_tlast_o !== want_item.last) begin
          $display("%0t: end of run mismatch, expected %b, got %b",
                   $time, want_item.last, m_axis_tlast_o);
          mismatches++;
        end
        if (m_axis_tuser_o !== want_item.ovf) begin
          $display("%0t: overflow mismatch, expected %b, got %b",
                   $time, want_item.ovf, m_axis_tuser_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    int blk;
    int n;
    int random_items;
    int waited;
    blk = 0;
    random_items = 0;
    waited = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < DIR_ROWS; r++) begin
      push_item(dir_rows[r].value, dir_rows[r].last, dir_rows[r].typed, dir_rows[r].want);
    end
    hold_until_drained();

    // Mostly short blocks; one exactly full, one overrun with the closing item dropped
    while (random_items < 180) begin
      if (blk == 2) n = CAP;
      else if (blk == 5) n = CAP + 2;
      else if ($urandom_range(0, 5) == 0) n = $urandom_range(11, 24);
      else n = $urandom_range(1, 10);
      for (int k = 0; k < n; k++) begin
        push_item(pick_value(), (k == n - 1), 1'b0, '0);
        random_items++;
      end
      if (blk % 6 == 3) hold_until_drained();
      blk++;
    end
    s_valid <= 1'b0;

    while (sorted_due.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    if (sorted_due.size() != 0) begin
      $display("%0t: %0d sorted items never arrived, next expected %h",
               $time, sorted_due.size(), sorted_due[0].value);
      mismatches++;
    end
    repeat (2 * CAP) @(posedge clk_i);

    $display("Sent %0d items in %0d blocks (%0d overran the store), checked %0d sorted items.",
             items_sent, blocks_closed, overflow_blocks, results_seen);
    if (mismatches == 0) begin
      $display("rank_sort_block regression: pass");
    end else begin
      $display("rank_sort_block regression: fail");
    end
    $finish;
  end

  initial begin
    #3ms;
    $display("Timed out with %0d sorted items outstanding.", sorted_due.size());
    $display("rank_sort_block regression: fail");
    $finish;
  end

endmodule
